@@ hdl/command_packet_deframer_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the command packet deframer
// Concurrent checks clocked on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COMMAND_PACKET_DEFRAMER_ASSERT_SVH
`define COMMAND_PACKET_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define CPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("deframer assertion failed");
`define CPD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("deframer forbidden condition seen");
`else
`define CPD_ASSERT(lbl, prop)
`define CPD_ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ hdl/cpd_pkg.sv @@
// ---------------------------------------------------------------------------
// cpd_pkg
// Constants and types shared by the command packet deframer modules.
// ---------------------------------------------------------------------------
package cpd_pkg;

  localparam logic [7:0] START_MARK  = 8'hAA;
  localparam logic [7:0] END_MARK    = 8'hFC;
  localparam logic [7:0] NODE_ID_RST = 8'h01;
  localparam logic [8:0] HDR_BYTES   = 9'd5;

  // Header byte positions within a frame.
  localparam logic [8:0] POS_START = 9'd0;
  localparam logic [8:0] POS_ID    = 9'd1;
  localparam logic [8:0] POS_TYPE  = 9'd2;
  localparam logic [8:0] POS_LEN   = 9'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [8:0] byte_position;
    logic       frame_end;
    logic       frame_ok;
    logic [7:0] command_code;
    logic [7:0] payload_length;
  } cpd_result_t;

endpackage

@@ hdl/cpd_in_stage.sv @@
// ---------------------------------------------------------------------------
// cpd_in_stage
// Input register: holds one received byte until the framer consumes it.
// ---------------------------------------------------------------------------
module cpd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_stall,
  input  logic [7:0] up_byte,
  output logic       dn_valid,
  input  logic       dn_stall,
  output logic [7:0] dn_byte
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       load;

  assign load     = !valid_r || !dn_stall;
  assign up_stall = !load;
  assign dn_valid = valid_r;
  assign dn_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      byte_r <= up_byte;
    end
  end

endmodule

@@ hdl/cpd_frame_ctrl.sv @@
// ---------------------------------------------------------------------------
// cpd_frame_ctrl
// Frame position counter, header capture and end-of-frame checks.
// ---------------------------------------------------------------------------
`include "command_packet_deframer_assert.svh"

module cpd_frame_ctrl
  import cpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_node_id,
  input  logic        advance,
  input  logic [7:0]  rx_byte,
  output cpd_result_t result
);

  logic [7:0] node_id_r;
  logic [8:0] cnt_r, cnt_nxt;
  logic [8:0] total_r, total_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] id_r, id_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] len_r, len_nxt;
  logic [8:0] next_pos;
  logic       last;

  assign next_pos = cnt_r + 9'd1;
  assign last     = (next_pos == total_r);

  // Header capture; the captured value is visible to this same byte's checks.
  always_comb begin
    first_nxt = first_r;
    id_nxt    = id_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    unique case (cnt_r)
      POS_START: first_nxt = rx_byte;
      POS_ID:    id_nxt    = rx_byte;
      POS_TYPE:  type_nxt  = rx_byte;
      POS_LEN:   len_nxt   = rx_byte;
      default: ;
    endcase
  end

  always_comb begin
    if (last) begin
      cnt_nxt   = '0;
      total_nxt = HDR_BYTES;
    end else begin
      cnt_nxt   = next_pos;
      total_nxt = total_r;
      if (cnt_r == POS_LEN) begin
        total_nxt = HDR_BYTES + {1'b0, rx_byte};
      end
    end
  end

  always_comb begin
    result.data_byte      = rx_byte;
    result.byte_position  = cnt_r;
    result.frame_end      = last;
    result.frame_ok       = last && (first_nxt == START_MARK) && (rx_byte == END_MARK)
                            && (id_nxt == node_id_r);
    result.command_code   = last ? type_nxt : 8'd0;
    result.payload_length = last ? len_nxt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= NODE_ID_RST;
      cnt_r     <= '0;
      total_r   <= HDR_BYTES;
      first_r   <= '0;
      id_r      <= '0;
      type_r    <= '0;
      len_r     <= '0;
    end else begin
      if (cfg_we) begin
        node_id_r <= cfg_node_id;
      end
      if (advance) begin
        cnt_r   <= cnt_nxt;
        total_r <= total_nxt;
        first_r <= first_nxt;
        id_r    <= id_nxt;
        type_r  <= type_nxt;
        len_r   <= len_nxt;
      end
    end
  end

  // A frame is never shorter than its header and trailer, nor longer than 260 bytes.
  `CPD_ASSERT(a_total_range, (total_r >= HDR_BYTES) && (total_r <= 9'd260))
  // The counter always stays inside the current frame.
  `CPD_ASSERT(a_cnt_in_frame, cnt_r < total_r)
  // Finishing a frame restarts the counter at the start byte.
  `CPD_ASSERT(a_restart, advance && last |=> (cnt_r == '0) && (total_r == HDR_BYTES))
  // Length byte sets the frame size from the received byte.
  `CPD_ASSERT(a_len_sets_total,
              advance && (cnt_r == POS_LEN) |=> total_r == HDR_BYTES + {1'b0, $past(rx_byte)})

endmodule

@@ hdl/cpd_out_stage.sv @@
// ---------------------------------------------------------------------------
// cpd_out_stage
// Result register: holds a finished result item until the consumer takes it.
// ---------------------------------------------------------------------------
module cpd_out_stage
  import cpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_stall,
  input  cpd_result_t up_result,
  output logic        dn_valid,
  input  logic        dn_stall,
  output cpd_result_t dn_result
);

  logic        valid_r;
  cpd_result_t result_r;
  logic        load;

  assign load      = !valid_r || !dn_stall;
  assign up_stall  = !load;
  assign dn_valid  = valid_r;
  assign dn_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      result_r <= up_result;
    end
  end

endmodule

@@ hdl/command_packet_deframer.sv @@
// ---------------------------------------------------------------------------
// command_packet_deframer
// Splits a received byte stream into start/id/type/length/payload/end frames.
// ---------------------------------------------------------------------------
// Every accepted byte yields one result item carrying the byte and its position
// in the frame; frames run back to back with no search for a start marker, and
// a frame lasts length byte + 5 bytes. On the end byte the item also reports
// whether the 0xAA start marker, the 0xFC end marker and the node id matched,
// plus the command type and payload length. The block takes one byte per
// cycle unless out_stall holds it; the counter update and compare sit between
// the input register and the result register.
// Write node_id (reset value 1) only while no item is in flight.
module command_packet_deframer
  import cpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic [8:0] out_byte_position,
  output logic       out_frame_end,
  output logic       out_frame_ok,
  output logic [7:0] out_command_code,
  output logic [7:0] out_payload_length,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_node_id
);

  logic        s1_valid;
  logic        s1_stall;
  logic [7:0]  s1_byte;
  logic        advance;
  cpd_result_t s1_result;
  cpd_result_t out_result;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && !s1_stall;

  cpd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_byte  (in_rx_byte),
    .dn_valid (s1_valid),
    .dn_stall (s1_stall),
    .dn_byte  (s1_byte)
  );

  cpd_frame_ctrl u_frame_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_node_id (cfg_node_id),
    .advance     (advance),
    .rx_byte     (s1_byte),
    .result      (s1_result)
  );

  cpd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s1_valid),
    .up_stall  (s1_stall),
    .up_result (s1_result),
    .dn_valid  (out_valid),
    .dn_stall  (out_stall),
    .dn_result (out_result)
  );

  assign out_data_byte      = out_result.data_byte;
  assign out_byte_position  = out_result.byte_position;
  assign out_frame_end      = out_result.frame_end;
  assign out_frame_ok       = out_result.frame_ok;
  assign out_command_code   = out_result.command_code;
  assign out_payload_length = out_result.payload_length;

endmodule
